[rtl/sci_pkg.sv]
// Shared types, codes and helper functions for the servo calibration interpolator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package sci_pkg;

	localparam int PULSE_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 16'd8000;
	localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 16'd40000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 1'd1;

	// Command codes.
	localparam logic [2:0] FN_SET_MODE = 3'd0;
	localparam logic [2:0] FN_NEXT     = 3'd1;
	localparam logic [2:0] FN_PREV     = 3'd2;
	localparam logic [2:0] FN_MOVE     = 3'd3;
	localparam logic [2:0] FN_JOG      = 3'd4;
	localparam logic [2:0] FN_SAVE     = 3'd5;

	// Operating modes.
	localparam logic [1:0] MD_IDLE  = 2'd0;
	localparam logic [1:0] MD_CALIB = 2'd1;
	localparam logic [1:0] MD_EXEC  = 2'd2;

	// Servo selects for jog.
	localparam logic [1:0] SERVO_ONE = 2'd1;
	localparam logic [1:0] SERVO_TWO = 2'd2;

	// Datapath operations issued by the controller.
	localparam logic [3:0] OP_NOP     = 4'd0;
	localparam logic [3:0] OP_CAPTURE = 4'd1;
	localparam logic [3:0] OP_SIMPLE  = 4'd2;
	localparam logic [3:0] OP_SEG     = 4'd3;
	localparam logic [3:0] OP_RLO     = 4'd4;
	localparam logic [3:0] OP_RHI     = 4'd5;
	localparam logic [3:0] OP_MUL     = 4'd6;
	localparam logic [3:0] OP_RCP     = 4'd7;
	localparam logic [3:0] OP_BCK     = 4'd8;
	localparam logic [3:0] OP_COR     = 4'd9;
	localparam logic [3:0] OP_FIN     = 4'd10;
	localparam logic [3:0] OP_LOAD    = 4'd11;

	typedef struct packed {
		logic [2:0]         func;
		logic [1:0]         mode_select;
		logic signed [15:0] first_angle;
		logic signed [15:0] second_angle;
		logic [1:0]         servo_select;
		logic signed [15:0] jog_delta;
	} in_item_t;

	typedef struct packed {
		logic [15:0] first_pulse;
		logic [15:0] second_pulse;
		logic        first_write;
		logic        second_write;
		logic        save_request;
		logic [1:0]  mode_now;
		logic [1:0]  point_now;
	} out_item_t;

	typedef struct packed {
		logic [3:0] op;
		logic       servo;
	} dp_cmd_t;

	typedef struct packed {
		logic is_move;
	} dp_stat_t;

	// Default table entry: 500 us per point step, saturated to 16'hFFFF.
	function automatic logic [PULSE_W-1:0] default_entry(input int i);
		int d;
		d = 8000 * (i + 1);
		if (d > 65535) return 16'hFFFF;
		return PULSE_W'(d);
	endfunction

	// A value below the minimum gives the minimum; any other value above the
	// maximum gives the maximum, also when the limits are crossed.
	function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [17:0] v,
			input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi);
		if (v < $signed({2'b00, lo})) return lo;
		if (v > $signed({2'b00, hi})) return hi;
		return v[PULSE_W-1:0];
	endfunction

endpackage

[rtl/sci_cmd_if.sv]
// Command channel: valid/ready handshake carrying one decoded command.
// Depends on sci_pkg for the command payload type.
interface sci_cmd_if;
	import sci_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/sci_res_if.sv]
// Result channel: valid/ready handshake carrying one servo update.
// Depends on sci_pkg for the result payload type.
interface sci_res_if;
	import sci_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/sci_datapath.sv]
// Datapath: calibration tables, mode and point registers, the shared interpolation
// unit and the result register. Depends on sci_pkg; steered by sci_ctrl.
module sci_datapath #(
	parameter int POINTS     = 4,
	parameter int ANGLE_STEP = 720
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sci_pkg::dp_cmd_t                   cmd,
	output sci_pkg::dp_stat_t                  stat,
	input  sci_pkg::in_item_t                  in_data,
	output sci_pkg::out_item_t                 out_data,
	input  logic                               cfg_we,
	input  logic [sci_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sci_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sci_pkg::*;

	localparam int IDX_W  = $clog2(POINTS);
	localparam int OFF_W  = $clog2(ANGLE_STEP);
	localparam int PROD_W = OFF_W + PULSE_W;
	localparam int REM_W  = OFF_W + 2;
	localparam int RCP_W  = PULSE_W + 1;
	localparam int RPR_W  = PROD_W + RCP_W;
	localparam int TOP    = (POINTS - 1) * ANGLE_STEP;
	// floor(2^PROD_W / ANGLE_STEP): the estimate is the quotient or one below it.
	localparam longint unsigned RECIP = (longint'(1) << PROD_W) / ANGLE_STEP;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

	logic [PULSE_W-1:0] tab1_q [POINTS];
	logic [PULSE_W-1:0] tab2_q [POINTS];
	logic [PULSE_W-1:0] pmin_q, pmax_q;
	logic [1:0]         mode_q;
	logic [IDX_W-1:0]   idx_q;
	in_item_t           cmd_q;
	logic [PULSE_W-1:0] p1_q, p2_q;
	logic               w1_q, w2_q, save_q;
	out_item_t          out_q;

	logic [IDX_W-1:0]   lo_addr_q, hi_addr_q;
	logic [OFF_W-1:0]   off_q;
	logic [PULSE_W-1:0] lo_q, dmag_q, qe_q, q_q;
	logic               neg_q;
	logic [PROD_W-1:0]  mag_q;
	logic [REM_W-1:0]   rem_q;

	logic [IDX_W-1:0]   nidx, simple_addr, rd_addr;
	logic [PULSE_W-1:0] ent1, ent2, ent_s;
	logic signed [17:0] jsum1, jsum2, fin_v;
	logic [PULSE_W-1:0] jog1, jog2, fin_p;
	logic signed [15:0] ang;
	int                 ang_i;
	logic [IDX_W-1:0]   seg;
	logic [IDX_W-1:0]   seg_lo, seg_hi;
	logic [OFF_W-1:0]   seg_off;
	logic [RPR_W-1:0]   rprod;
	logic [PROD_W-1:0]  back;

	assign stat.is_move = (in_data.func == FN_MOVE) && (mode_q == MD_EXEC);

	always_comb begin
		if (cmd_q.func == FN_NEXT) begin
			nidx = (idx_q < LAST_IDX) ? idx_q + 1'b1 : idx_q;
		end else begin
			nidx = (idx_q != '0) ? idx_q - 1'b1 : idx_q;
		end
		case (cmd_q.func)
			FN_SET_MODE: simple_addr = '0;
			FN_NEXT, FN_PREV: simple_addr = nidx;
			default: simple_addr = idx_q;
		endcase
		case (cmd.op)
			OP_RLO: rd_addr = lo_addr_q;
			OP_RHI: rd_addr = hi_addr_q;
			default: rd_addr = simple_addr;
		endcase
	end

	// One read per table per cycle, at the address chosen above.
	assign ent1  = tab1_q[rd_addr];
	assign ent2  = tab2_q[rd_addr];
	assign ent_s = cmd.servo ? ent2 : ent1;

	assign jsum1 = $signed({2'b00, ent1}) + 18'(cmd_q.jog_delta);
	assign jsum2 = $signed({2'b00, ent2}) + 18'(cmd_q.jog_delta);
	assign jog1  = clamp_pulse(jsum1, pmin_q, pmax_q);
	assign jog2  = clamp_pulse(jsum2, pmin_q, pmax_q);

	// Segment search: the highest breakpoint at or below the angle, held at the end points outside the table.
	always_comb begin
		ang   = cmd.servo ? cmd_q.second_angle : cmd_q.first_angle;
		ang_i = int'(ang);
		seg   = '0;
		for (int k = 1; k < POINTS; k++) begin
			if (ang_i >= k * ANGLE_STEP) seg = IDX_W'(k);
		end
		if (ang_i <= 0) begin
			seg_lo  = '0;
			seg_hi  = '0;
			seg_off = '0;
		end else if (ang_i >= TOP) begin
			seg_lo  = LAST_IDX;
			seg_hi  = LAST_IDX;
			seg_off = '0;
		end else begin
			seg_lo  = seg;
			seg_hi  = seg + 1'b1;
			seg_off = OFF_W'(ang_i - int'(seg) * ANGLE_STEP);
		end
	end

	assign rprod = RPR_W'(mag_q) * RPR_W'(RCP_W'(RECIP));
	assign back  = PROD_W'(qe_q) * PROD_W'(ANGLE_STEP);
	assign fin_v = neg_q ? $signed({2'b00, lo_q}) - $signed({2'b00, q_q})
		: $signed({2'b00, lo_q}) + $signed({2'b00, q_q});
	assign fin_p = clamp_pulse(fin_v, pmin_q, pmax_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POINTS; i++) begin
				tab1_q[i] <= default_entry(i);
				tab2_q[i] <= default_entry(i);
			end
			pmin_q <= PULSE_MIN_RST;
			pmax_q <= PULSE_MAX_RST;
			mode_q <= MD_IDLE;
			idx_q  <= '0;
			p1_q   <= '0;
			p2_q   <= '0;
			w1_q   <= 1'b0;
			w2_q   <= 1'b0;
			save_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PULSE_MIN: pmin_q <= cfg_data;
					REG_PULSE_MAX: pmax_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_CAPTURE: begin
					p1_q   <= '0;
					p2_q   <= '0;
					w1_q   <= 1'b0;
					w2_q   <= 1'b0;
					save_q <= 1'b0;
				end
				OP_SIMPLE: begin
					case (cmd_q.func)
						FN_SET_MODE: begin
							case (cmd_q.mode_select)
								MD_CALIB: begin
									mode_q <= MD_CALIB;
									idx_q  <= '0;
									p1_q   <= ent1;
									p2_q   <= ent2;
									w1_q   <= 1'b1;
									w2_q   <= 1'b1;
								end
								MD_IDLE, MD_EXEC: mode_q <= cmd_q.mode_select;
								default: ;
							endcase
						end
						FN_NEXT, FN_PREV: begin
							if (mode_q == MD_CALIB) begin
								idx_q <= nidx;
								p1_q  <= ent1;
								p2_q  <= ent2;
								w1_q  <= 1'b1;
								w2_q  <= 1'b1;
							end
						end
						FN_JOG: begin
							if (mode_q == MD_CALIB) begin
								case (cmd_q.servo_select)
									SERVO_ONE: begin
										tab1_q[idx_q] <= jog1;
										p1_q          <= jog1;
										w1_q          <= 1'b1;
									end
									SERVO_TWO: begin
										tab2_q[idx_q] <= jog2;
										p2_q          <= jog2;
										w2_q          <= 1'b1;
									end
									default: ;
								endcase
							end
						end
						FN_SAVE: save_q <= 1'b1;
						default: ;
					endcase
				end
				OP_FIN: begin
					if (cmd.servo) begin
						p2_q <= fin_p;
						w2_q <= 1'b1;
					end else begin
						p1_q <= fin_p;
						w1_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Interpolation unit and holding registers: one operation per cycle.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: cmd_q <= in_data;
			OP_SEG: begin
				lo_addr_q <= seg_lo;
				hi_addr_q <= seg_hi;
				off_q     <= seg_off;
			end
			OP_RLO: lo_q <= ent_s;
			OP_RHI: begin
				neg_q  <= ent_s < lo_q;
				dmag_q <= (ent_s < lo_q) ? lo_q - ent_s : ent_s - lo_q;
			end
			OP_MUL: mag_q <= PROD_W'(off_q) * PROD_W'(dmag_q);
			OP_RCP: qe_q <= PULSE_W'(rprod >> PROD_W);
			OP_BCK: rem_q <= REM_W'(mag_q - back);
			OP_COR: q_q <= qe_q + ((rem_q >= REM_W'(ANGLE_STEP)) ? 16'd1 : 16'd0);
			OP_LOAD: begin
				out_q.first_pulse  <= p1_q;
				out_q.second_pulse <= p2_q;
				out_q.first_write  <= w1_q;
				out_q.second_write <= w2_q;
				out_q.save_request <= save_q;
				out_q.mode_now     <= mode_q;
				out_q.point_now    <= 2'(idx_q);
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

endmodule

[rtl/sci_ctrl.sv]
// Controller: accepts a request, sequences the datapath through one command
// and hands the result to the output register. Depends on sci_pkg.
module sci_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sci_pkg::dp_stat_t stat,
	output sci_pkg::dp_cmd_t  cmd
);
	import sci_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SIMPLE = 4'd1;
	localparam logic [3:0] ST_SEG    = 4'd2;
	localparam logic [3:0] ST_RLO    = 4'd3;
	localparam logic [3:0] ST_RHI    = 4'd4;
	localparam logic [3:0] ST_MUL    = 4'd5;
	localparam logic [3:0] ST_RCP    = 4'd6;
	localparam logic [3:0] ST_BCK    = 4'd7;
	localparam logic [3:0] ST_COR    = 4'd8;
	localparam logic [3:0] ST_FIN    = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       servo_q, servo_d;
	logic       out_valid_q;
	logic       load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		servo_d   = servo_q;
		cmd.op    = OP_NOP;
		cmd.servo = servo_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					servo_d = 1'b0;
					state_d = stat.is_move ? ST_SEG : ST_SIMPLE;
				end
			end
			ST_SIMPLE: begin
				cmd.op  = OP_SIMPLE;
				state_d = ST_DONE;
			end
			ST_SEG: begin
				cmd.op  = OP_SEG;
				state_d = ST_RLO;
			end
			ST_RLO: begin
				cmd.op  = OP_RLO;
				state_d = ST_RHI;
			end
			ST_RHI: begin
				cmd.op  = OP_RHI;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_RCP;
			end
			ST_RCP: begin
				cmd.op  = OP_RCP;
				state_d = ST_BCK;
			end
			ST_BCK: begin
				cmd.op  = OP_BCK;
				state_d = ST_COR;
			end
			ST_COR: begin
				cmd.op  = OP_COR;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.op = OP_FIN;
				// Servo one first, then the same sequence for servo two.
				if (!servo_q) begin
					servo_d = 1'b1;
					state_d = ST_SEG;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load) begin
					cmd.op  = OP_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			servo_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			servo_q <= servo_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/servo_calibration_interpolator.sv]
// Two-servo calibration table lookup with piecewise-linear interpolation.
// Instantiates sci_ctrl and sci_datapath; depends on sci_pkg and the channel interfaces.
//
// Each request is one decoded command and yields exactly one result. Set-mode,
// next, previous, jog, save and ignored commands take the simple step; a move in
// execute mode goes through the single shared interpolation unit, which runs
// segment search, two table reads, multiply, reciprocal multiply, back-multiply,
// correction and clamp one step per cycle for servo one and then for servo two.
// One request is in work at a time; a finished result sits in an output register,
// so the next request is taken while it waits. The user must write pulse_min and
// pulse_max only while no request is in flight; the block does not enforce this.
module servo_calibration_interpolator #(
	parameter int POINTS     = 4,
	parameter int ANGLE_STEP = 720
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sci_cmd_if.sink                        cmd,
	sci_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [sci_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sci_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sci_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	sci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (dstat),
		.cmd       (dcmd)
	);

	sci_datapath #(
		.POINTS     (POINTS),
		.ANGLE_STEP (ANGLE_STEP)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dcmd),
		.stat      (dstat),
		.in_data   (cmd.data),
		.out_data  (res.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

`ifndef SYNTHESIS
	// A result that drives neither servo reports a zero pulse width for both.
	a_idle_pulse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.data.first_write && !res.data.second_write
		|-> res.data.first_pulse == '0 && res.data.second_pulse == '0)
		else $error("undriven servo carries a nonzero pulse");

	// A save request never drives a servo.
	a_save_alone: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.save_request
		|-> !res.data.first_write && !res.data.second_write)
		else $error("save result also drives a servo");

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("request taken while the previous one is still in work");
`endif

endmodule

[test/tb_top.sv]
// Testbench for the servo calibration interpolator: directed and random command traffic,
// a behavioral predictor of both servo outputs and an in-order checker of every result.
// Depends on sci_pkg and the sci_cmd_if / sci_res_if channel interfaces.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sci_pkg::*;

	localparam int POINTS        = 4;
	localparam int ANGLE_STEP    = 720;
	localparam int TOP_ANGLE     = (POINTS - 1) * ANGLE_STEP;
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int MAX_PRINTS    = 60;

	// Codes the block has to ignore.
	localparam logic [2:0] FN_UNUSED_LO = 3'd6;
	localparam logic [2:0] FN_UNUSED_HI = 3'd7;
	localparam logic [1:0] MD_UNUSED    = 2'd3;
	localparam logic [1:0] SERVO_NONE   = 2'd0;
	localparam logic [1:0] SERVO_BOTH   = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sci_cmd_if cmd_ch();
	sci_res_if res_ch();

	servo_calibration_interpolator #(
		.POINTS(POINTS),
		.ANGLE_STEP(ANGLE_STEP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor copy of the block state and limits.
	logic [15:0] tbl_one [POINTS];
	logic [15:0] tbl_two [POINTS];
	logic [1:0]  cur_mode;
	int          cur_point;
	logic [15:0] lim_lo;
	logic [15:0] lim_hi;

	out_item_t pending_updates [$];

	int errors;
	int prints;
	int idle_cycles;
	int n_requests;
	int n_results;
	int n_moves;
	int n_jogs;
	int n_steps;
	int n_limit_settings;
	bit wd_armed;
	bit hold_request;
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 16);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_angle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return int'($urandom_range(0, TOP_ANGLE + 200)) - 100;
		if (r < 85) return int'($urandom_range(0, POINTS - 1)) * ANGLE_STEP
			+ int'($urandom_range(0, 2)) - 1;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int pick_delta();
		if ($urandom_range(0, 99) < 80) return int'($urandom_range(0, 4000)) - 2000;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic logic [1:0] pick_servo();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return SERVO_ONE;
		if (r < 90) return SERVO_TWO;
		if (r < 95) return SERVO_NONE;
		return SERVO_BOTH;
	endfunction

	function automatic in_item_t noise_item();
		logic [63:0] raw;
		in_item_t it;
		raw = {$urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		return it;
	endfunction

	// A value below the low limit gives the low limit, anything above the high
	// limit gives the high limit, which also covers crossed limits.
	function automatic logic [15:0] fit_pulse(int v);
		if (v < int'(lim_lo)) return lim_lo;
		if (v > int'(lim_hi)) return lim_hi;
		return v[15:0];
	endfunction

	function automatic int interp_pulse(int ang, bit on_second);
		int seg;
		int off;
		int lo;
		int hi;
		if (ang <= 0) return on_second ? int'(tbl_two[0]) : int'(tbl_one[0]);
		if (ang >= TOP_ANGLE)
			return on_second ? int'(tbl_two[POINTS-1]) : int'(tbl_one[POINTS-1]);
		seg = ang / ANGLE_STEP;
		off = ang - seg * ANGLE_STEP;
		lo  = on_second ? int'(tbl_two[seg]) : int'(tbl_one[seg]);
		hi  = on_second ? int'(tbl_two[seg+1]) : int'(tbl_one[seg+1]);
		// Signed int division truncates toward zero, as the block does.
		return lo + (off * (hi - lo)) / ANGLE_STEP;
	endfunction

	function automatic out_item_t predict_servo_update(in_item_t c);
		out_item_t r;
		int idx;
		r = '0;
		idx = cur_point;
		case (c.func)
			FN_SET_MODE: begin
				if (c.mode_select == MD_CALIB) begin
					cur_mode = MD_CALIB;
					idx = 0;
					r.first_pulse  = tbl_one[0];
					r.second_pulse = tbl_two[0];
					r.first_write  = 1'b1;
					r.second_write = 1'b1;
				end else if (c.mode_select == MD_IDLE || c.mode_select == MD_EXEC) begin
					cur_mode = c.mode_select;
				end
			end
			FN_NEXT, FN_PREV: begin
				if (cur_mode == MD_CALIB) begin
					if (c.func == FN_NEXT) begin
						if (idx < POINTS - 1) idx++;
					end else if (idx > 0) begin
						idx--;
					end
					r.first_pulse  = tbl_one[idx];
					r.second_pulse = tbl_two[idx];
					r.first_write  = 1'b1;
					r.second_write = 1'b1;
					n_steps++;
				end
			end
			FN_MOVE: begin
				if (cur_mode == MD_EXEC) begin
					r.first_pulse  = fit_pulse(interp_pulse(int'(c.first_angle), 1'b0));
					r.second_pulse = fit_pulse(interp_pulse(int'(c.second_angle), 1'b1));
					r.first_write  = 1'b1;
					r.second_write = 1'b1;
					n_moves++;
				end
			end
			FN_JOG: begin
				if (cur_mode == MD_CALIB) begin
					if (c.servo_select == SERVO_ONE) begin
						tbl_one[idx] = fit_pulse(int'(tbl_one[idx]) + int'(c.jog_delta));
						r.first_pulse = tbl_one[idx];
						r.first_write = 1'b1;
						n_jogs++;
					end else if (c.servo_select == SERVO_TWO) begin
						tbl_two[idx] = fit_pulse(int'(tbl_two[idx]) + int'(c.jog_delta));
						r.second_pulse = tbl_two[idx];
						r.second_write = 1'b1;
						n_jogs++;
					end
				end
			end
			FN_SAVE: r.save_request = 1'b1;
			default: ;
		endcase
		cur_point   = idx;
		r.mode_now  = cur_mode;
		r.point_now = idx[1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (prints < MAX_PRINTS) begin
			$display("%0t: result %0d, %s: got %0d, expected %0d", $time, n_results, what,
				got, want);
			prints++;
		end
	endtask

	task automatic send_request(in_item_t it);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= it;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		pending_updates.push_back(predict_servo_update(it));
		n_requests++;
	endtask

	task automatic issue(logic [2:0] fn, logic [1:0] msel, int a1, int a2, logic [1:0] sel,
			int delta);
		in_item_t it;
		it.func         = fn;
		it.mode_select  = msel;
		it.first_angle  = 16'(a1);
		it.second_angle = 16'(a2);
		it.servo_select = sel;
		it.jog_delta    = 16'(delta);
		send_request(it);
	endtask

	task automatic drain_servo_updates();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_updates.size() != 0) @(posedge clk);
	endtask

	// Limits change only with the block idle and every request answered.
	task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		drain_servo_updates();
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PULSE_MIN) lim_lo = val;
		else lim_hi = val;
	endtask

	task automatic set_limits(logic [15:0] lo, logic [15:0] hi);
		write_limit(REG_PULSE_MIN, lo);
		write_limit(REG_PULSE_MAX, hi);
		n_limit_settings++;
	endtask

	task automatic test_idle_commands();
		issue(FN_MOVE, MD_IDLE, 2000, 1000, SERVO_ONE, 0);
		issue(FN_NEXT, MD_CALIB, 0, 0, SERVO_ONE, 0);
		issue(FN_PREV, MD_CALIB, 0, 0, SERVO_TWO, 0);
		issue(FN_JOG, MD_IDLE, 0, 0, SERVO_ONE, 500);
		issue(FN_SAVE, MD_EXEC, -1, -1, SERVO_BOTH, -1);
		issue(FN_UNUSED_LO, MD_CALIB, 100, 100, SERVO_ONE, 100);
		issue(FN_UNUSED_HI, MD_CALIB, 100, 100, SERVO_TWO, 100);
		issue(FN_SET_MODE, MD_UNUSED, 0, 0, SERVO_NONE, 0);
	endtask

	task automatic test_calibration_walk();
		issue(FN_SET_MODE, MD_CALIB, 0, 0, SERVO_NONE, 0);
		repeat (POINTS) issue(FN_NEXT, MD_IDLE, 0, 0, SERVO_NONE, 0);
		issue(FN_JOG, MD_IDLE, 0, 0, SERVO_ONE, 32767);
		issue(FN_JOG, MD_IDLE, 0, 0, SERVO_TWO, -32768);
		issue(FN_JOG, MD_IDLE, 0, 0, SERVO_NONE, 1000);
		issue(FN_JOG, MD_IDLE, 0, 0, SERVO_BOTH, 1000);
		// Calibrate again while calibrating, then step below the first point.
		issue(FN_SET_MODE, MD_CALIB, 0, 0, SERVO_NONE, 0);
		issue(FN_PREV, MD_IDLE, 0, 0, SERVO_NONE, 0);
	endtask

	task automatic test_execute_moves();
		issue(FN_SET_MODE, MD_EXEC, 0, 0, SERVO_NONE, 0);
		issue(FN_MOVE, MD_IDLE, -32768, 32767, SERVO_NONE, 0);
		issue(FN_MOVE, MD_IDLE, 0, TOP_ANGLE, SERVO_NONE, 0);
		issue(FN_MOVE, MD_IDLE, 1, ANGLE_STEP - 1, SERVO_NONE, 0);
		issue(FN_MOVE, MD_IDLE, ANGLE_STEP, TOP_ANGLE - 1, SERVO_NONE, 0);
		issue(FN_MOVE, MD_IDLE, 1500, -1, SERVO_NONE, 0);
	endtask

	task automatic test_limit_settings();
		logic [15:0] lows [5];
		logic [15:0] highs [5];
		lows  = '{16'd0, 16'd65535, 16'd20000, 16'd65535, 16'd0};
		highs = '{16'd65535, 16'd0, 16'd20000, 16'd65535, 16'd0};
		for (int s = 0; s < 5; s++) begin
			set_limits(lows[s], highs[s]);
			issue(FN_SET_MODE, MD_EXEC, 0, 0, SERVO_NONE, 0);
			repeat (4) issue(FN_MOVE, MD_IDLE, pick_angle(), pick_angle(), SERVO_NONE, 0);
			issue(FN_SET_MODE, MD_CALIB, 0, 0, SERVO_NONE, 0);
			repeat (4) issue(FN_JOG, MD_IDLE, 0, 0, pick_servo(), pick_delta());
		end
		set_limits(PULSE_MIN_RST, PULSE_MAX_RST);
	endtask

	task automatic test_backpressure();
		issue(FN_SET_MODE, MD_EXEC, 0, 0, SERVO_NONE, 0);
		// The receiver holds off while requests keep coming back to back.
		tx_gaps_on   = 1'b0;
		hold_request = 1'b1;
		repeat (16) issue(FN_MOVE, MD_IDLE, pick_angle(), pick_angle(), SERVO_NONE, 0);
		tx_gaps_on = 1'b1;
		drain_servo_updates();
		repeat (6) issue(FN_MOVE, MD_IDLE, pick_angle(), pick_angle(), SERVO_NONE, 0);
	endtask

	// One stretch of random traffic: a calibration session, an execution session
	// or plain noise, each with its own idling pattern.
	task automatic run_command_block();
		int kind;
		int len;
		int r;
		kind = $urandom_range(0, 9);
		len  = $urandom_range(4, 20);
		tx_gaps_on = ($urandom_range(0, 6) != 0);
		rx_gaps_on = ($urandom_range(0, 6) != 0);
		if ($urandom_range(0, 19) == 0) drain_servo_updates();
		if (kind < 4) begin
			issue(FN_SET_MODE, MD_CALIB, $urandom, $urandom, 2'($urandom), $urandom);
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 10) send_request(noise_item());
				else if (r < 30)
					issue(FN_NEXT, 2'($urandom), $urandom, $urandom, 2'($urandom),
						$urandom);
				else if (r < 50)
					issue(FN_PREV, 2'($urandom), $urandom, $urandom, 2'($urandom),
						$urandom);
				else
					issue(FN_JOG, 2'($urandom), $urandom, $urandom, pick_servo(),
						pick_delta());
			end
		end else if (kind < 8) begin
			issue(FN_SET_MODE, MD_EXEC, $urandom, $urandom, 2'($urandom), $urandom);
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 10) send_request(noise_item());
				else if (r < 15)
					issue(FN_SAVE, 2'($urandom), $urandom, $urandom, 2'($urandom),
						$urandom);
				else
					issue(FN_MOVE, 2'($urandom), pick_angle(), pick_angle(),
						2'($urandom), $urandom);
			end
		end else begin
			repeat (len) send_request(noise_item());
		end
	endtask

	task automatic test_random_traffic();
		int start;
		int next_change;
		int lo;
		start = n_requests;
		next_change = start;
		while (n_requests - start < RANDOM_ITEMS) begin
			if (n_requests >= next_change) begin
				case ($urandom_range(0, 5))
					0: set_limits(PULSE_MIN_RST, PULSE_MAX_RST);
					1: set_limits(16'd0, 16'd65535);
					2: begin
						lo = $urandom_range(0, 30000);
						set_limits(16'(lo), 16'($urandom_range(lo, 65535)));
					end
					3: begin
						lo = $urandom_range(20000, 65535);
						set_limits(16'(lo), 16'($urandom_range(0, lo - 1)));
					end
					4: set_limits(16'($urandom), 16'($urandom));
					default: set_limits(16'd12000, 16'd30000);
				endcase
				next_change = n_requests + 250;
			end
			run_command_block();
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (rx_gaps_on) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t got;
		out_item_t want;
		if (wd_armed) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
			else idle_cycles++;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			n_results++;
			got = res_ch.data;
			if (pending_updates.size() == 0) begin
				report_mismatch("unexpected result, first_pulse", 32'(got.first_pulse), 0);
			end else begin
				want = pending_updates.pop_front();
				if (got.first_pulse !== want.first_pulse)
					report_mismatch("first_pulse", 32'(got.first_pulse),
						32'(want.first_pulse));
				if (got.second_pulse !== want.second_pulse)
					report_mismatch("second_pulse", 32'(got.second_pulse),
						32'(want.second_pulse));
				if (got.first_write !== want.first_write)
					report_mismatch("first_write", 32'(got.first_write),
						32'(want.first_write));
				if (got.second_write !== want.second_write)
					report_mismatch("second_write", 32'(got.second_write),
						32'(want.second_write));
				if (got.save_request !== want.save_request)
					report_mismatch("save_request", 32'(got.save_request),
						32'(want.save_request));
				if (got.mode_now !== want.mode_now)
					report_mismatch("mode_now", 32'(got.mode_now), 32'(want.mode_now));
				if (got.point_now !== want.point_now)
					report_mismatch("point_now", 32'(got.point_now), 32'(want.point_now));
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		res_ch.ready = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		arst_n       = 1'b0;
		for (int i = 0; i < POINTS; i++) begin
			tbl_one[i] = (8000 * (i + 1) > 65535) ? 16'hFFFF : 16'(8000 * (i + 1));
			tbl_two[i] = tbl_one[i];
		end
		cur_mode  = MD_IDLE;
		cur_point = 0;
		lim_lo    = PULSE_MIN_RST;
		lim_hi    = PULSE_MAX_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n   = 1'b1;
		wd_armed = 1'b1;

		test_idle_commands();
		test_calibration_walk();
		test_execute_moves();
		test_limit_settings();
		test_backpressure();
		test_random_traffic();

		drain_servo_updates();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (pending_updates.size() != 0) begin
			want_left_over : begin
				out_item_t left;
				left = pending_updates.pop_front();
				report_mismatch("missing result, first_pulse", 0, 32'(left.first_pulse));
			end
		end
		$display("Sent %0d requests: %0d moves, %0d jogs, %0d point steps checked.",
			n_requests, n_moves, n_jogs, n_steps);
		$display("Compared %0d servo updates under %0d pulse limit settings, %0d mismatches.",
			n_results, n_limit_settings, errors);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[servo_calibration_interpolator.f]
rtl/sci_pkg.sv
rtl/sci_cmd_if.sv
rtl/sci_res_if.sv
rtl/sci_datapath.sv
rtl/sci_ctrl.sv
rtl/servo_calibration_interpolator.sv
test/tb_top.sv
